[rtl/thasm_pkg.sv]
// ----------------------------------------------------------------------------
// thasm_pkg
// Shared types and constants for the Thumb add, subtract and multiply
// execute block.
// ----------------------------------------------------------------------------
package thasm_pkg;

  localparam int XLEN       = 32;
  localparam int REG_IDX_W  = 4;
  localparam int NUM_REGS   = 15;
  localparam int IMM_W      = 8;
  localparam int OP_W       = 4;
  localparam int CYCLE_W    = 6;
  localparam int MUL_CYCLES = 32;

  localparam logic [REG_IDX_W-1:0] REG_SP = 4'd13;
  localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

  localparam logic [XLEN-1:0] ADR_ALIGN_MASK = 32'hFFFF_FFFC;

  typedef enum logic [OP_W-1:0] {
    OP_ADCS    = 4'd0,
    OP_ADDS_I3 = 4'd1,
    OP_ADDS_I8 = 4'd2,
    OP_ADDS_R  = 4'd3,
    OP_ADD_R   = 4'd4,
    OP_ADD_SP  = 4'd5,
    OP_ADR     = 4'd6,
    OP_SUBS_I3 = 4'd7,
    OP_SUBS_I8 = 4'd8,
    OP_SUBS_R  = 4'd9,
    OP_SUB_SP  = 4'd10,
    OP_SBCS    = 4'd11,
    OP_RSBS    = 4'd12,
    OP_MULS    = 4'd13
  } op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

endpackage

[rtl/thumb_add_sub_mul_execute_top.sv]
// ----------------------------------------------------------------------------
// thumb_add_sub_mul_execute_top
// Execute stage for decoded Thumb add, subtract and multiply instructions,
// holding r0 to r14 and the N, Z, C and V flags.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel is one decoded instruction together with
//   the PC value that it reads. Each request produces exactly one result on
//   the out_ channel: the register write (if any), the branch indication,
//   the flags after the instruction, the modelled cycle count and the fault.
//   Both channels use valid/ready; a request moves on when both are high.
//   The request and its two operands are captured in the capture stage at
//   the accepting edge, and the arithmetic lands in the result register
//   when that stage advances. Throughput is one request per cycle while the
//   receiver takes results. The register file write and the flag update land on
//   the same edge that loads the result register, and the operand read of
//   the following request bypasses that write, so dependent instructions
//   run back to back. A stalled receiver holds the result register; the
//   input is still taken while the capture stage is empty or can drain into
//   it, so up to two requests wait before in_ready falls.
//   Reset clears the pipeline valid bits, the flags and the per-register
//   valid bits, so every register reads as zero until written.
// ----------------------------------------------------------------------------
module thumb_add_sub_mul_execute_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [thasm_pkg::OP_W-1:0]          in_op,
  input  logic [thasm_pkg::REG_IDX_W-1:0]     in_rd,
  input  logic [thasm_pkg::REG_IDX_W-1:0]     in_rn,
  input  logic [thasm_pkg::REG_IDX_W-1:0]     in_rm,
  input  logic [thasm_pkg::IMM_W-1:0]         in_imm,
  input  logic [thasm_pkg::XLEN-1:0]          in_pc_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_write_enable,
  output logic [thasm_pkg::REG_IDX_W-1:0]     out_write_index,
  output logic [thasm_pkg::XLEN-1:0]          out_write_value,
  output logic                                out_branch_taken,
  output logic                                out_flag_neg,
  output logic                                out_flag_zero,
  output logic                                out_flag_carry,
  output logic                                out_flag_overflow,
  output logic [thasm_pkg::CYCLE_W-1:0]       out_cycle_count,
  output logic                                out_fault
);
  import thasm_pkg::*;

  // Capture stage.
  logic                  s1_vld_r;
  op_t                   s1_op_r;
  logic [REG_IDX_W-1:0]  s1_rd_r;
  logic [REG_IDX_W-1:0]  s1_rm_r;
  logic [REG_IDX_W-1:0]  s1_a_addr_r;
  logic [IMM_W-1:0]      s1_imm_r;
  logic [XLEN-1:0]       s1_pc_r;
  logic [XLEN-1:0]       s1_a_data_r;
  logic [XLEN-1:0]       s1_b_data_r;

  // Architectural state.
  logic [XLEN-1:0]       reg_mem [0:NUM_REGS-1];
  logic [NUM_REGS-1:0]   reg_vld_r;
  flags_t                flags_r;
  flags_t                flags_nxt;

  // Result register.
  logic                  out_vld_r;
  logic                  out_we_r;
  logic [REG_IDX_W-1:0]  out_idx_r;
  logic [XLEN-1:0]       out_val_r;
  logic                  out_br_r;
  flags_t                out_flags_r;
  logic [CYCLE_W-1:0]    out_cyc_r;
  logic                  out_fault_r;

  logic                  in_fire;
  logic                  adv;
  logic [REG_IDX_W-1:0]  a_addr;
  op_t                   in_op_e;

  logic [XLEN-1:0]       a_val;
  logic [XLEN-1:0]       b_val;
  logic [XLEN-1:0]       imm_ext;
  logic [XLEN-1:0]       imm_x4;
  logic [XLEN-1:0]       add_a;
  logic [XLEN-1:0]       add_b;
  logic                  add_cin;
  logic [XLEN:0]         add_sum;
  logic [XLEN-1:0]       add_res;
  logic [XLEN-1:0]       mul_res;

  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_idx;
  logic [XLEN-1:0]       wr_val;
  logic                  res_we;
  logic [REG_IDX_W-1:0]  res_idx;
  logic [XLEN-1:0]       res_val;
  logic                  res_br;
  logic [CYCLE_W-1:0]    res_cyc;
  logic                  res_fault;
  logic [REG_IDX_W-1:0]  dest;
  logic [XLEN-1:0]       val;
  logic                  do_wr;

  assign adv      = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || adv;
  assign in_fire  = in_valid && in_ready;
  assign in_op_e  = op_t'(in_op);

  // Port A serves the first operand: rd for two-operand forms, SP for the
  // SP forms, rn otherwise. Port B always reads rm.
  always_comb begin
    unique case (in_op_e) inside
      OP_ADCS, OP_ADDS_I8, OP_ADD_R, OP_SUBS_I8, OP_SBCS, OP_MULS: a_addr = in_rd;
      OP_ADD_SP, OP_SUB_SP:                                         a_addr = REG_SP;
      default:                                                      a_addr = in_rn;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  // Operand read with bypass of the write retiring on the same edge.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_op_e;
      s1_rd_r     <= in_rd;
      s1_rm_r     <= in_rm;
      s1_a_addr_r <= a_addr;
      s1_imm_r    <= in_imm;
      s1_pc_r     <= in_pc_value;
      if (wr_en && wr_idx == a_addr) begin
        s1_a_data_r <= wr_val;
      end else if (a_addr != REG_PC && reg_vld_r[a_addr]) begin
        s1_a_data_r <= reg_mem[a_addr];
      end else begin
        s1_a_data_r <= '0;
      end
      if (wr_en && wr_idx == in_rm) begin
        s1_b_data_r <= wr_val;
      end else if (in_rm != REG_PC && reg_vld_r[in_rm]) begin
        s1_b_data_r <= reg_mem[in_rm];
      end else begin
        s1_b_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      reg_mem[wr_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r <= '0;
      flags_r   <= '0;
    end else if (adv) begin
      flags_r <= flags_nxt;
      if (wr_en) begin
        reg_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign a_val   = (s1_a_addr_r == REG_PC) ? s1_pc_r : s1_a_data_r;
  assign b_val   = (s1_rm_r == REG_PC) ? s1_pc_r : s1_b_data_r;
  assign imm_ext = {{(XLEN-IMM_W){1'b0}}, s1_imm_r};
  assign imm_x4  = {imm_ext[XLEN-3:0], 2'b00};

  // One shared adder; subtracts add the inverted operand.
  always_comb begin
    add_a   = a_val;
    add_b   = b_val;
    add_cin = 1'b0;
    unique case (s1_op_r) inside
      OP_ADCS:                add_cin = flags_r.c;
      OP_ADDS_I3, OP_ADDS_I8: add_b = imm_ext;
      OP_ADD_SP:              add_b = imm_x4;
      OP_ADR: begin
        add_a = s1_pc_r & ADR_ALIGN_MASK;
        add_b = imm_x4;
      end
      OP_SUBS_I3, OP_SUBS_I8: begin
        add_b   = ~imm_ext;
        add_cin = 1'b1;
      end
      OP_SUBS_R: begin
        add_b   = ~b_val;
        add_cin = 1'b1;
      end
      OP_SUB_SP: begin
        add_b   = ~imm_x4;
        add_cin = 1'b1;
      end
      OP_SBCS: begin
        add_b   = ~b_val;
        add_cin = flags_r.c;
      end
      OP_RSBS: begin
        add_a   = '0;
        add_b   = ~a_val;
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{XLEN{1'b0}}, add_cin};
  assign add_res = add_sum[XLEN-1:0];
  assign mul_res = a_val * b_val;

  always_comb begin
    flags_nxt = flags_r;
    dest      = s1_rd_r;
    val       = add_res;
    do_wr     = 1'b1;
    res_br    = 1'b0;
    res_fault = 1'b0;
    res_cyc   = CYCLE_W'(1);
    unique case (s1_op_r) inside
      OP_ADCS, OP_ADDS_I3, OP_ADDS_I8, OP_ADDS_R, OP_SUBS_I3, OP_SUBS_I8,
      OP_SUBS_R, OP_SBCS, OP_RSBS: begin
        flags_nxt.n = add_res[XLEN-1];
        flags_nxt.z = (add_res == '0);
        flags_nxt.c = add_sum[XLEN];
        flags_nxt.v = (add_a[XLEN-1] ^ add_res[XLEN-1]) &
                      (add_b[XLEN-1] ^ add_res[XLEN-1]);
      end
      OP_ADD_R: begin
        if (s1_rd_r == REG_PC && s1_rm_r == REG_PC) begin
          res_fault = 1'b1;
          do_wr     = 1'b0;
        end else if (s1_rd_r == REG_PC) begin
          val     = {add_res[XLEN-1:1], 1'b0};
          res_br  = 1'b1;
          res_cyc = CYCLE_W'(2);
        end
      end
      OP_ADD_SP, OP_ADR: ;
      OP_SUB_SP: dest = REG_SP;
      OP_MULS: begin
        val         = mul_res;
        flags_nxt.n = mul_res[XLEN-1];
        flags_nxt.z = (mul_res == '0);
        res_cyc     = CYCLE_W'(MUL_CYCLES);
      end
      default: do_wr = 1'b0;
    endcase
    // A write to the PC other than the branch form is dropped.
    res_we  = do_wr && (dest != REG_PC || res_br);
    res_idx = res_we ? dest : '0;
    res_val = res_we ? val : '0;
  end

  assign wr_en  = adv && res_we && !res_br;
  assign wr_idx = res_idx;
  assign wr_val = res_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_we_r    <= res_we;
      out_idx_r   <= res_idx;
      out_val_r   <= res_val;
      out_br_r    <= res_br;
      out_flags_r <= flags_nxt;
      out_cyc_r   <= res_cyc;
      out_fault_r <= res_fault;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_write_enable  = out_we_r;
  assign out_write_index   = out_idx_r;
  assign out_write_value   = out_val_r;
  assign out_branch_taken  = out_br_r;
  assign out_flag_neg      = out_flags_r.n;
  assign out_flag_zero     = out_flags_r.z;
  assign out_flag_carry    = out_flags_r.c;
  assign out_flag_overflow = out_flags_r.v;
  assign out_cycle_count   = out_cyc_r;
  assign out_fault         = out_fault_r;

  // A faulting add never reports a register write.
  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_fault_r |-> !out_we_r)
    else $error("fault reported together with a register write");

  // A branch writes the PC with an even target and reports its modelled cycle count.
  a_branch_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_br_r |->
      out_we_r && out_idx_r == REG_PC && !out_val_r[0] && out_cyc_r == CYCLE_W'(2))
    else $error("malformed branch result");

  // The register file is never written at the PC index.
  a_no_pc_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_idx != REG_PC)
    else $error("register file write at the PC index");

  // A held capture stage must block the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |-> !in_ready)
    else $error("input accepted while capture stage is held");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("pipeline not empty after reset");

endmodule
